// File: rtl/ppsm_pkg.sv
// ----------------------------------------------------------------------------
// ppsm_pkg
// Shared types, codes and constants of the pulse period speed meter.
// ----------------------------------------------------------------------------
package ppsm_pkg;

  // Default for the top level parameter
  localparam int CHANNELS_DEF = 2;

  // Capture counter width, fixed by the input payload
  localparam int CAPTURE_BITS = 16;

  // Field widths
  localparam int CAP_W     = CAPTURE_BITS;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 24;
  localparam int TOL_W     = 16;
  localparam int STALE_W   = 16;
  localparam int TICK_W    = 8;
  localparam int PPR_W     = 8;
  localparam int GAIN_W    = 16;
  localparam int RPM_W     = 16;
  localparam int VERDICT_W = 2;
  localparam int COUNT_W   = 32;

  // Arithmetic widths
  localparam int unsigned US_PER_MS  = 1000;
  localparam int unsigned RPM_NUM    = 60000000;
  localparam int unsigned RPM_NUM_Q8 = RPM_NUM / 256;   // gain is Q8.8
  localparam int US_MUL_W   = 10;                        // bits of US_PER_MS
  localparam int EXK_W      = TIME_W + US_MUL_W;
  localparam int AGE_US_W   = STALE_W + US_MUL_W;        // age_ms * 1000 when fresh
  localparam int DIV_W      = 34;                        // 234375*gain, eff*ppr

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam logic [RPM_W-1:0]    RPM_MAX    = '1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register map (word index)
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PERIOD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WRAP_TOL   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STALE      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TICK       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PPR        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN       = 3'd5;

  // Register reset values
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 24'd11900;
  localparam logic [TOL_W-1:0]    WRAP_TOL_RST   = 16'd50;
  localparam logic [STALE_W-1:0]  STALE_RST      = 16'd400;
  localparam logic [TICK_W-1:0]   TICK_RST       = 8'd10;
  localparam logic [PPR_W-1:0]    PPR_RST        = 8'd11;
  localparam logic [GAIN_W-1:0]   GAIN_RST       = 16'd256;

  // Request types
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_QUERY   = 1'b1;

  // Classified command codes
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BAD_CH  = 2'd2;

  // Verdicts
  localparam logic [VERDICT_W-1:0] VERDICT_FIRST  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NOISE  = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DESYNC = 2'd3;

  typedef struct packed {
    logic [PERIOD_W-1:0] min_period_us;
    logic [TOL_W-1:0]    wrap_tolerance_ms;
    logic [STALE_W-1:0]  stale_ms;
    logic [TICK_W-1:0]   tick_us;
    logic [PPR_W-1:0]    edges_per_rev;
    logic [GAIN_W-1:0]   cal_gain_q8;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic              channel;
    logic [CAP_W-1:0]  capture_value;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [PERIOD_W-1:0]  period_out_us;
    logic [RPM_W-1:0]     speed_rpm;
    logic                 fresh;
    logic [COUNT_W-1:0]   noise_total;
    logic [COUNT_W-1:0]   desync_total;
  } out_item_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    in_item_t         item;
  } q_item_t;

endpackage

// File: rtl/ppsm_front.sv
// ----------------------------------------------------------------------------
// ppsm_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ppsm_front #(
  parameter int CHANNELS = ppsm_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ppsm_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_pop,
  output ppsm_pkg::q_item_t  q_item
);
  import ppsm_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t         q_mem_r   [QUEUE_DEPTH];
  q_item_t         q_mem_nxt [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            push;
  logic            ch_ok;
  q_item_t         entry;

  assign in_stall = (count_r == QC_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    ch_ok      = (int'(in_data.channel) < CHANNELS);
    entry.item = in_data;
    if (!ch_ok) begin
      entry.cmd = CMD_BAD_CH;
    end else if (in_data.req_type == REQ_QUERY) begin
      entry.cmd = CMD_QUERY;
    end else begin
      entry.cmd = CMD_CAPTURE;
    end
  end

  always_comb begin
    q_mem_nxt  = q_mem_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      q_mem_nxt[wr_ptr_r] = entry;
      wr_ptr_nxt          = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_mem_r <= q_mem_nxt;
  end

endmodule

// File: rtl/ppsm_div.sv
// ----------------------------------------------------------------------------
// ppsm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppsm_div #(
  parameter int W = ppsm_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     den_r, den_nxt;
  logic [W:0]       shifted;
  logic [W:0]       trial;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // no borrow means the divisor fits
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

endmodule

// File: rtl/ppsm_back.sv
// ----------------------------------------------------------------------------
// ppsm_back
// Per-channel state, edge classification, speed computation and result register.
// ----------------------------------------------------------------------------
module ppsm_back #(
  parameter int CHANNELS = ppsm_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ppsm_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  ppsm_pkg::q_item_t          q_item,
  output logic                       div_start,
  output logic [ppsm_pkg::DIV_W-1:0] div_num,
  output logic [ppsm_pkg::DIV_W-1:0] div_den,
  input  logic                       div_done,
  input  logic [ppsm_pkg::DIV_W-1:0] div_quo,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ppsm_pkg::out_item_t        out_data
);
  import ppsm_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = CAPTURE_BITS + TICK_W;
  localparam int SUB_W = 33;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_LOAD   = 4'd1;
  localparam logic [ST_W-1:0] ST_SUB    = 4'd2;
  localparam logic [ST_W-1:0] ST_SCALE  = 4'd3;
  localparam logic [ST_W-1:0] ST_DECIDE = 4'd4;
  localparam logic [ST_W-1:0] ST_FRESH  = 4'd5;
  localparam logic [ST_W-1:0] ST_AGEUS  = 4'd6;
  localparam logic [ST_W-1:0] ST_EFF    = 4'd7;
  localparam logic [ST_W-1:0] ST_DEN    = 4'd8;
  localparam logic [ST_W-1:0] ST_START  = 4'd9;
  localparam logic [ST_W-1:0] ST_DIV    = 4'd10;
  localparam logic [ST_W-1:0] ST_OUT    = 4'd11;

  logic [ST_W-1:0]      state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // per-channel state
  logic [CAP_W-1:0]     ref_cap_r     [CHANNELS];
  logic [CAP_W-1:0]     ref_cap_nxt   [CHANNELS];
  logic [TIME_W-1:0]    ref_time_r    [CHANNELS];
  logic [TIME_W-1:0]    ref_time_nxt  [CHANNELS];
  logic [PERIOD_W-1:0]  per_r         [CHANNELS];
  logic [PERIOD_W-1:0]  per_nxt       [CHANNELS];
  logic                 noref_r       [CHANNELS];
  logic                 noref_nxt     [CHANNELS];
  logic [COUNT_W-1:0]   glitch_r      [CHANNELS];
  logic [COUNT_W-1:0]   glitch_nxt    [CHANNELS];
  logic [COUNT_W-1:0]   desync_r      [CHANNELS];
  logic [COUNT_W-1:0]   desync_nxt    [CHANNELS];

  // current transaction and working values
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [RPM_W-1:0]     rpm_r, rpm_nxt;
  logic [PW-1:0]        period_r, period_nxt;
  logic [TIME_W-1:0]    elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]    ex_r, ex_nxt;
  logic                 ex_ok_r, ex_ok_nxt;
  logic [EXK_W-1:0]     exk_r, exk_nxt;
  logic [STALE_W-1:0]   age_lo_r, age_lo_nxt;
  logic [AGE_US_W-1:0]  age_us_r, age_us_nxt;
  logic [AGE_US_W-1:0]  eff_r, eff_nxt;
  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [DIV_W-1:0]     den_r, den_nxt;

  logic [SUB_W-1:0]        cap_diff;
  logic [CAPTURE_BITS-1:0] diff;
  logic [TIME_W-1:0]       age;
  logic [PPR_W-1:0]        ppr_eff;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign div_num   = num_r;
  assign div_den   = den_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ref_cap_nxt   = ref_cap_r;
    ref_time_nxt  = ref_time_r;
    per_nxt       = per_r;
    noref_nxt     = noref_r;
    glitch_nxt    = glitch_r;
    desync_nxt    = desync_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    cap_nxt       = cap_r;
    now_nxt       = now_r;
    verdict_nxt   = verdict_r;
    fresh_nxt     = fresh_r;
    rpm_nxt       = rpm_r;
    period_nxt    = period_r;
    elapsed_nxt   = elapsed_r;
    ex_nxt        = ex_r;
    ex_ok_nxt     = ex_ok_r;
    exk_nxt       = exk_r;
    age_lo_nxt    = age_lo_r;
    age_us_nxt    = age_us_r;
    eff_nxt       = eff_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;

    cap_diff = SUB_W'(cap_r) - SUB_W'(ref_cap_r[ch_r]);
    diff     = cap_diff[CAPTURE_BITS-1:0];
    age      = now_r - ref_time_r[ch_r];
    ppr_eff  = (cfg.edges_per_rev == '0) ? PPR_W'(1) : cfg.edges_per_rev;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_item.cmd;
          ch_nxt      = CH_W'(q_item.item.channel);
          cap_nxt     = q_item.item.capture_value;
          now_nxt     = q_item.item.now_ms;
          verdict_nxt = VERDICT_FIRST;
          fresh_nxt   = 1'b0;
          rpm_nxt     = '0;
          unique case (q_item.cmd)
            CMD_CAPTURE: state_nxt = ST_LOAD;
            CMD_QUERY:   state_nxt = ST_FRESH;
            default:     state_nxt = ST_OUT;
          endcase
        end
      end
      ST_LOAD: begin
        period_nxt  = PW'(diff) * PW'(cfg.tick_us);
        elapsed_nxt = now_r - ref_time_r[ch_r];
        state_nxt   = ST_SUB;
      end
      ST_SUB: begin
        ex_ok_nxt = elapsed_r > TIME_W'(cfg.wrap_tolerance_ms);
        ex_nxt    = elapsed_r - TIME_W'(cfg.wrap_tolerance_ms);
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        // elapsed - tol > floor(period/1000)  <=>  (elapsed - tol)*1000 > period
        exk_nxt   = EXK_W'(ex_r) * EXK_W'(US_PER_MS);
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (noref_r[ch_r]) begin
          verdict_nxt        = VERDICT_FIRST;
          noref_nxt[ch_r]    = 1'b0;
          ref_cap_nxt[ch_r]  = cap_r;
          ref_time_nxt[ch_r] = now_r;
        end else if (64'(period_r) < 64'(cfg.min_period_us)) begin
          verdict_nxt      = VERDICT_NOISE;
          glitch_nxt[ch_r] = glitch_r[ch_r] + 1'b1;
        end else begin
          if (ex_ok_r && (64'(exk_r) > 64'(period_r))) begin
            verdict_nxt      = VERDICT_DESYNC;
            desync_nxt[ch_r] = desync_r[ch_r] + 1'b1;
            per_nxt[ch_r]    = '0;
          end else begin
            verdict_nxt   = VERDICT_ACCEPT;
            per_nxt[ch_r] = (64'(period_r) > 64'(PERIOD_MAX)) ? PERIOD_MAX
                                                               : PERIOD_W'(period_r);
          end
          ref_cap_nxt[ch_r]  = cap_r;
          ref_time_nxt[ch_r] = now_r;
        end
        state_nxt = ST_FRESH;
      end
      ST_FRESH: begin
        fresh_nxt  = (age <= TIME_W'(cfg.stale_ms)) && (per_r[ch_r] != '0);
        age_lo_nxt = age[STALE_W-1:0];
        state_nxt  = (cmd_r == CMD_QUERY && fresh_nxt) ? ST_AGEUS : ST_OUT;
      end
      ST_AGEUS: begin
        // fresh implies age fits the stale limit width
        age_us_nxt = AGE_US_W'(age_lo_r) * AGE_US_W'(US_PER_MS);
        state_nxt  = ST_EFF;
      end
      ST_EFF: begin
        eff_nxt   = (age_us_r > AGE_US_W'(per_r[ch_r])) ? age_us_r
                                                        : AGE_US_W'(per_r[ch_r]);
        num_nxt   = DIV_W'(cfg.cal_gain_q8) * DIV_W'(RPM_NUM_Q8);
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        den_nxt   = DIV_W'(eff_r) * DIV_W'(ppr_eff);
        state_nxt = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          rpm_nxt   = (div_quo > DIV_W'(RPM_MAX)) ? RPM_MAX : div_quo[RPM_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_BAD_CH) begin
            out_data_nxt = '0;
          end else begin
            out_data_nxt.verdict       = verdict_r;
            out_data_nxt.period_out_us = per_r[ch_r];
            out_data_nxt.speed_rpm     = rpm_r;
            out_data_nxt.fresh         = fresh_r;
            out_data_nxt.noise_total   = glitch_r[ch_r];
            out_data_nxt.desync_total  = desync_r[ch_r];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ref_cap_r[i]  <= '0;
        ref_time_r[i] <= '0;
        per_r[i]      <= '0;
        noref_r[i]    <= 1'b1;
        glitch_r[i]   <= '0;
        desync_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ref_cap_r   <= ref_cap_nxt;
      ref_time_r  <= ref_time_nxt;
      per_r       <= per_nxt;
      noref_r     <= noref_nxt;
      glitch_r    <= glitch_nxt;
      desync_r    <= desync_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cmd_r      <= cmd_nxt;
    ch_r       <= ch_nxt;
    cap_r      <= cap_nxt;
    now_r      <= now_nxt;
    verdict_r  <= verdict_nxt;
    fresh_r    <= fresh_nxt;
    rpm_r      <= rpm_nxt;
    period_r   <= period_nxt;
    elapsed_r  <= elapsed_nxt;
    ex_r       <= ex_nxt;
    ex_ok_r    <= ex_ok_nxt;
    exk_r      <= exk_nxt;
    age_lo_r   <= age_lo_nxt;
    age_us_r   <= age_us_nxt;
    eff_r      <= eff_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
  end

endmodule

// File: rtl/pulse_period_speed_meter.sv
// ----------------------------------------------------------------------------
// pulse_period_speed_meter
// Multi-channel pulse period meter with RPM query and APB register file.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                          | payload
//  in      | in  | in_valid / in_stall                | in_item_t
//  out     | out | out_valid / out_stall              | out_item_t
//  apb     | in  | psel, penable, pwrite, pready = 1  | paddr, pwdata, prdata
//
//  One transaction is processed at a time by the back end; a two-entry queue
//  keeps accepting input meanwhile until full. A capture passes the LOAD, SUB,
//  SCALE, DECIDE, FRESH and OUT states; a fresh query FRESH, AGEUS, EFF, DEN,
//  START, the 34-step serial divider and OUT; a stale or empty query FRESH and
//  OUT, a bad channel OUT alone. Results wait in the output register while
//  out_stall is high. Reset restores registers and clears all channels.
// ----------------------------------------------------------------------------
module pulse_period_speed_meter #(
  parameter int CHANNELS = ppsm_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ppsm_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ppsm_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppsm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ppsm_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic                 q_valid;
  logic                 q_pop;
  q_item_t              q_item;
  logic                 div_start;
  logic [DIV_W-1:0]     div_num;
  logic [DIV_W-1:0]     div_den;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_PERIOD: cfg_nxt.min_period_us     = pwdata[PERIOD_W-1:0];
        REG_WRAP_TOL:   cfg_nxt.wrap_tolerance_ms = pwdata[TOL_W-1:0];
        REG_STALE:      cfg_nxt.stale_ms          = pwdata[STALE_W-1:0];
        REG_TICK:       cfg_nxt.tick_us           = pwdata[TICK_W-1:0];
        REG_PPR:        cfg_nxt.edges_per_rev     = pwdata[PPR_W-1:0];
        REG_GAIN:       cfg_nxt.cal_gain_q8       = pwdata[GAIN_W-1:0];
        default:        cfg_nxt                   = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_PERIOD: prdata = 32'(cfg_r.min_period_us);
      REG_WRAP_TOL:   prdata = 32'(cfg_r.wrap_tolerance_ms);
      REG_STALE:      prdata = 32'(cfg_r.stale_ms);
      REG_TICK:       prdata = 32'(cfg_r.tick_us);
      REG_PPR:        prdata = 32'(cfg_r.edges_per_rev);
      REG_GAIN:       prdata = 32'(cfg_r.cal_gain_q8);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_period_us     <= MIN_PERIOD_RST;
      cfg_r.wrap_tolerance_ms <= WRAP_TOL_RST;
      cfg_r.stale_ms          <= STALE_RST;
      cfg_r.tick_us           <= TICK_RST;
      cfg_r.edges_per_rev     <= PPR_RST;
      cfg_r.cal_gain_q8       <= GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ppsm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  ppsm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ppsm_div #(
    .W (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

// File: sim/tb_pulse_period_speed_meter.sv
// ----------------------------------------------------------------------------
// tb_pulse_period_speed_meter
// Self-checking testbench for the two-channel pulse period speed meter.
// A scoreboard class keeps its own copy of the per-channel capture state and
// the register file and predicts every result. The stimulus starts with
// directed edges and queries and then runs through several register settings
// with mostly well-formed random pulse trains. Random gaps on the input and
// random stalls on the output, plus one long output hold-off, exercise the
// handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pulse_period_speed_meter;
  import ppsm_pkg::*;

  localparam int          NUM_PHASES      = 6;
  localparam int          ITEMS_PER_PHASE = 320;
  localparam int          SETTLE_CYCLES   = 64;
  localparam int          SQUEEZE_CYCLES  = 400;
  localparam longint      RUN_LIMIT_NS    = 20_000_000;
  localparam longint unsigned MS_TO_US    = 1000;
  localparam longint unsigned RPM_NUMERATOR = 60_000_000;
  localparam longint unsigned Q8_ONE      = 256;
  localparam longint unsigned SPEED_LIMIT = 65535;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // --------------------------------------------------------------------------
  // Scoreboard: register mirror, per-channel state, expected results
  // --------------------------------------------------------------------------
  class speed_scoreboard;
    logic [PERIOD_W-1:0] min_period_us;
    logic [TOL_W-1:0]    wrap_tolerance_ms;
    logic [STALE_W-1:0]  stale_ms;
    logic [TICK_W-1:0]   tick_us;
    logic [PPR_W-1:0]    edges_per_rev;
    logic [GAIN_W-1:0]   cal_gain_q8;

    logic [CAP_W-1:0]    ref_capture [2];
    logic [TIME_W-1:0]   ref_time_ms [2];
    logic [PERIOD_W-1:0] per_store [2];
    bit                  no_reference [2];
    logic [COUNT_W-1:0]  noise_count [2];
    logic [COUNT_W-1:0]  desync_count [2];

    out_item_t   expected_results [$];
    int unsigned failures;

    function new();
      min_period_us     = MIN_PERIOD_RST;
      wrap_tolerance_ms = WRAP_TOL_RST;
      stale_ms          = STALE_RST;
      tick_us           = TICK_RST;
      edges_per_rev     = PPR_RST;
      cal_gain_q8       = GAIN_RST;
      for (int i = 0; i < 2; i++) begin
        ref_capture[i]  = '0;
        ref_time_ms[i]  = '0;
        per_store[i]    = '0;
        no_reference[i] = 1'b1;
        noise_count[i]  = '0;
        desync_count[i] = '0;
      end
      failures = 0;
    endfunction

    // Upper bits beyond a register's width are dropped
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_MIN_PERIOD: min_period_us     = value[PERIOD_W-1:0];
        REG_WRAP_TOL:   wrap_tolerance_ms = value[TOL_W-1:0];
        REG_STALE:      stale_ms          = value[STALE_W-1:0];
        REG_TICK:       tick_us           = value[TICK_W-1:0];
        REG_PPR:        edges_per_rev     = value[PPR_W-1:0];
        REG_GAIN:       cal_gain_q8       = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function out_item_t meter_step(in_item_t it);
      out_item_t         r;
      int                ch;
      logic [CAP_W-1:0]  ticks;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] age;
      longint unsigned   per, eff, age_us, ppr, den, num, q;
      r  = '0;
      ch = int'(it.channel);
      if (it.req_type == REQ_CAPTURE) begin
        if (no_reference[ch]) begin
          r.verdict        = VERDICT_FIRST;
          no_reference[ch] = 1'b0;
          ref_capture[ch]  = it.capture_value;
          ref_time_ms[ch]  = it.now_ms;
        end else begin
          ticks   = it.capture_value - ref_capture[ch];
          per     = ticks;
          per     = per * tick_us;
          elapsed = it.now_ms - ref_time_ms[ch];
          if (per < min_period_us) begin
            // noise keeps the old reference
            r.verdict       = VERDICT_NOISE;
            noise_count[ch] = noise_count[ch] + 1;
          end else begin
            if (elapsed > per / MS_TO_US + wrap_tolerance_ms) begin
              r.verdict        = VERDICT_DESYNC;
              desync_count[ch] = desync_count[ch] + 1;
              per_store[ch]    = '0;
            end else begin
              r.verdict     = VERDICT_ACCEPT;
              per_store[ch] = (per > PERIOD_MAX) ? PERIOD_MAX : PERIOD_W'(per);
            end
            ref_capture[ch] = it.capture_value;
            ref_time_ms[ch] = it.now_ms;
          end
        end
      end
      age     = it.now_ms - ref_time_ms[ch];
      r.fresh = (age <= stale_ms) && (per_store[ch] != '0);
      if (it.req_type == REQ_QUERY && r.fresh) begin
        eff    = per_store[ch];
        age_us = age;
        age_us = age_us * MS_TO_US;
        if (age_us > eff) eff = age_us;
        ppr = (edges_per_rev == '0) ? 1 : edges_per_rev;
        den = eff * ppr * Q8_ONE;
        num = RPM_NUMERATOR * cal_gain_q8;
        q   = (den == 0) ? 0 : num / den;
        r.speed_rpm = (q > SPEED_LIMIT) ? RPM_W'(SPEED_LIMIT) : RPM_W'(q);
      end
      r.period_out_us = per_store[ch];
      r.noise_total   = noise_count[ch];
      r.desync_total  = desync_count[ch];
      return r;
    endfunction

    function void note_item(in_item_t it);
      expected_results.push_back(meter_step(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing expected: verdict %0d period %0d rpm %0d",
                   $realtime, got.verdict, got.period_out_us, got.speed_rpm);
        return;
      end
      want = expected_results.pop_front();
      if (got.verdict !== want.verdict || got.period_out_us !== want.period_out_us ||
          got.speed_rpm !== want.speed_rpm || got.fresh !== want.fresh ||
          got.noise_total !== want.noise_total || got.desync_total !== want.desync_total) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch", $realtime);
          $display("  exp verdict %0d period %0d rpm %0d fresh %0d noise %0d desync %0d",
                   want.verdict, want.period_out_us, want.speed_rpm, want.fresh,
                   want.noise_total, want.desync_total);
          $display("  got verdict %0d period %0d rpm %0d fresh %0d noise %0d desync %0d",
                   got.verdict, got.period_out_us, got.speed_rpm, got.fresh,
                   got.noise_total, got.desync_total);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  speed_scoreboard sb = new();

  bit                  steady_input = 1'b0;
  bit                  squeeze_req  = 1'b0;
  logic [CAP_W-1:0]    gen_cap  [2];
  logic [TIME_W-1:0]   gen_time [2];

  pulse_period_speed_meter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    int gap;
    gap = steady_input ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic send_fields(input logic req, input logic ch, input logic [CAP_W-1:0] cap,
                             input logic [TIME_W-1:0] now);
    in_item_t it;
    it.req_type      = req;
    it.channel       = ch;
    it.capture_value = cap;
    it.now_ms        = now;
    send_item(it);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] junk;
    junk = $urandom;
    if (width < 32) value = value | (junk << width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Drop valid, drain everything outstanding, then let the back end go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int ph);
    logic [31:0] v_min, v_tol, v_stale, v_tick, v_ppr, v_gain;
    case (ph)
      0: begin
        v_min = 0; v_tol = 0; v_stale = 65535; v_tick = 1; v_ppr = 1; v_gain = 65535;
      end
      1: begin
        v_min = 24'hFFFFFF; v_tol = 65535; v_stale = 0; v_tick = 255; v_ppr = 255;
        v_gain = 0;
      end
      2: begin
        // zero tick and zero pulses per rev
        v_min = 0; v_tol = $urandom_range(0, 100); v_stale = 1000; v_tick = 0; v_ppr = 0;
        v_gain = 256;
      end
      default: begin
        v_min   = $urandom_range(0, 30000);
        v_tol   = $urandom_range(0, 300);
        v_stale = $urandom_range(20, 3000);
        v_tick  = $urandom_range(1, 40);
        v_ppr   = $urandom_range(1, 32);
        v_gain  = $urandom_range(0, 65535);
      end
    endcase
    write_reg(REG_MIN_PERIOD, v_min, PERIOD_W);
    write_reg(REG_WRAP_TOL, v_tol, TOL_W);
    write_reg(REG_STALE, v_stale, STALE_W);
    write_reg(REG_TICK, v_tick, TICK_W);
    write_reg(REG_PPR, v_ppr, PPR_W);
    write_reg(REG_GAIN, v_gain, GAIN_W);
    write_reg((ph % 2) ? REG_UNUSED_HI : REG_UNUSED_LO, $urandom, 32);
    for (int i = 0; i < 2; i++) begin
      gen_cap[i]  = CAP_W'($urandom);
      gen_time[i] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000)
                                               : $urandom;
    end
  endtask

  // Pulse trains that follow the current tick and tolerance, with noise and
  // desync edges and queries at various ages mixed in
  function automatic in_item_t next_random_item();
    in_item_t    it;
    int          ch;
    int unsigned kind, ticks, ticks_lo, ticks_hi, per, tick, tol, stale, age;
    it.req_type      = REQ_CAPTURE;
    it.channel       = 1'($urandom_range(0, 1));
    ch               = int'(it.channel);
    tick             = sb.tick_us;
    tol              = sb.wrap_tolerance_ms;
    stale            = sb.stale_ms;
    ticks_lo         = (tick == 0) ? 0 : (sb.min_period_us + tick - 1) / tick;
    if (ticks_lo > 65535) ticks_lo = 65535;
    ticks_hi         = (ticks_lo + 3000 > 65535) ? 65535 : ticks_lo + 3000;
    kind             = $urandom_range(0, 99);
    if (kind < 45) begin
      ticks = $urandom_range(0, 1) ? $urandom_range(ticks_lo, ticks_hi)
                                   : $urandom_range(ticks_lo, 65535);
      per   = ticks * tick;
      gen_cap[ch]  = CAP_W'(gen_cap[ch] + ticks);
      gen_time[ch] = gen_time[ch] + per / 1000 + $urandom_range(0, (tol > 30) ? 30 : tol);
      it.capture_value = gen_cap[ch];
      it.now_ms        = gen_time[ch];
    end else if (kind < 55) begin
      ticks = (ticks_lo == 0) ? 0 : $urandom_range(0, ticks_lo - 1);
      it.capture_value = CAP_W'(gen_cap[ch] + ticks);
      it.now_ms        = gen_time[ch] + $urandom_range(0, 5);
    end else if (kind < 60) begin
      ticks = $urandom_range(0, 65535);
      per   = ticks * tick;
      gen_cap[ch]  = CAP_W'(gen_cap[ch] + ticks);
      gen_time[ch] = gen_time[ch] + per / 1000 + tol + 1 + $urandom_range(0, 100000);
      it.capture_value = gen_cap[ch];
      it.now_ms        = gen_time[ch];
    end else if (kind < 90) begin
      age = $urandom_range(0, 1) ? $urandom_range(0, stale) : $urandom_range(0, 2 * stale + 10);
      it.req_type      = REQ_QUERY;
      it.capture_value = CAP_W'($urandom);
      it.now_ms        = gen_time[ch] + age;
    end else begin
      it.req_type      = 1'($urandom_range(0, 1));
      it.capture_value = CAP_W'($urandom);
      it.now_ms        = $urandom;
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    int run;
    bit squeezed;
    squeezed = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        run = $urandom_range(1, 40);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values (min 11900 us, tol 50, stale 400, tick 10)
    send_fields(REQ_QUERY,   1'b0, 16'hFFFF, 32'h0000_0000);  // no reference yet
    send_fields(REQ_CAPTURE, 1'b0, 16'hFFF0, 32'hFFFF_FFF0);  // first sync
    send_fields(REQ_CAPTURE, 1'b0, 16'h0400, 32'hFFFF_FFF5);  // short: noise
    send_fields(REQ_CAPTURE, 1'b0, 16'h0500, 32'h0000_0005);  // wraps on both fields
    send_fields(REQ_QUERY,   1'b0, 16'h0000, 32'h0000_000A);
    send_fields(REQ_QUERY,   1'b0, 16'h0000, 32'd405);        // age exactly at stale limit
    send_fields(REQ_QUERY,   1'b0, 16'h0000, 32'd406);        // one past: stale
    send_fields(REQ_CAPTURE, 1'b0, 16'h0CD0, 32'h0000_1000);  // desync
    send_fields(REQ_QUERY,   1'b0, 16'h0000, 32'h0000_1000);  // period cleared
    send_fields(REQ_CAPTURE, 1'b1, 16'h0000, 32'h0000_0000);
    send_fields(REQ_CAPTURE, 1'b1, 16'hFFFF, 32'h0000_0000);  // longest period
    send_fields(REQ_QUERY,   1'b1, 16'h0000, 32'h0000_0000);
    send_fields(REQ_CAPTURE, 1'b1, 16'h04A5, 32'd12);         // period equal to minimum
    send_fields(REQ_CAPTURE, 1'b1, 16'h094A, 32'd13);         // one tick short
    send_fields(REQ_CAPTURE, 1'b1, 16'h1C79, 32'd123);        // elapsed at tolerance
    send_fields(REQ_CAPTURE, 1'b1, 16'h344D, 32'd235);        // one ms over: desync
    send_fields(REQ_QUERY,   1'b1, 16'hFFFF, 32'hFFFF_FFFF);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      configure(ph);
      steady_input = (ph % 3 == 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == 40) squeeze_req = 1'b1;
        send_item(next_random_item());
      end
    end
    drain();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_pulse_period_speed_meter OK");
    end else begin
      $display("tb_pulse_period_speed_meter NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb_pulse_period_speed_meter NOT OK");
    $finish;
  end

endmodule
